/* rtl/hpg_pkg.sv */
// ----------------------------------------------------------------------------
// hpg_pkg
// Shared types and constants of the Heap permutation generator.
// ----------------------------------------------------------------------------
package hpg_pkg;

   localparam int MAX_LEN     = 8;
   localparam int SYMBOL_BITS = 8;
   localparam int POS_BITS    = $clog2(MAX_LEN);
   localparam int LEN_BITS    = 4;
   localparam int NUM_BITS    = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   typedef struct packed {
      logic                   opcode;
      logic [POS_BITS-1:0]    position;
      logic [SYMBOL_BITS-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [POS_BITS-1:0]    slot;
      logic [SYMBOL_BITS-1:0] value;
      logic [NUM_BITS-1:0]    perm_number;
      logic                   last;
      logic                   exhausted;
   } rsp_type;

endpackage

/* rtl/heap_permutation_generator.sv */
// ----------------------------------------------------------------------------
// heap_permutation_generator
// Heap's algorithm over a small symbol store; one beat per emitted symbol.
// ----------------------------------------------------------------------------
// A load command leaves busy low. A next command emits length beats on
// consecutive cycles. The first beat comes on the cycle after the first busy
// cycle, because the symbol store is read through one registered port. Then
// the sequencer walks the level counters, one level a cycle. A swap then reads
// both slots and writes them back through the same store port. A next command
// after exhaustion gives its single beat the next cycle and leaves busy low.
// Each rsp_valid beat lasts one cycle and the receiver cannot stall it.
module heap_permutation_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  hpg_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output hpg_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hpg_pkg::LEN_BITS-1:0]   csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EMIT = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_RDA  = 3'd3;
   localparam logic [2:0] S_RDB  = 3'd4;
   localparam logic [2:0] S_WRA  = 3'd5;
   localparam logic [2:0] S_WRB  = 3'd6;

   localparam int PB = hpg_pkg::POS_BITS;
   localparam int LB = hpg_pkg::LEN_BITS;
   localparam int SB = hpg_pkg::SYMBOL_BITS;
   localparam int NB = hpg_pkg::NUM_BITS;

   logic [SB-1:0] store_ff [hpg_pkg::MAX_LEN];

   logic [2:0]    state_ff, state_in;
   logic [LB-1:0] len_ff, len_in;
   logic [LB-1:0] n_ff, n_in;
   logic [PB-1:0] k_ff, k_in;
   logic [LB-1:0] i_ff, i_in;
   logic [LB-1:0] level_ff, level_in;
   logic [NB-1:0] count_ff, count_in;
   logic          finished_ff, finished_in;
   logic [PB-1:0] cnt_ff [hpg_pkg::MAX_LEN];
   logic [PB-1:0] cnt_in [hpg_pkg::MAX_LEN];
   logic [PB-1:0] swap_a_ff, swap_a_in;
   logic [PB-1:0] swap_b_ff, swap_b_in;
   logic [SB-1:0] rd_ff;
   logic [SB-1:0] tmp_ff;
   logic          pend_ff, pend_in;
   logic [PB-1:0] slot_ff, slot_in;
   logic          last_ff, last_in;
   logic          exh_ff, exh_in;

   logic          accept;
   logic [LB-1:0] eff_len;
   logic          rd_en;
   logic [PB-1:0] rd_addr;
   logic          wr_en;
   logic [PB-1:0] wr_addr;
   logic [SB-1:0] wr_data;
   logic [PB-1:0] cur_cnt;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   always_comb begin
      if (len_ff == '0) begin
         eff_len = LB'(1);
      end else if (len_ff > LB'(hpg_pkg::MAX_LEN)) begin
         eff_len = LB'(hpg_pkg::MAX_LEN);
      end else begin
         eff_len = len_ff;
      end
   end

   assign cur_cnt = cnt_ff[i_ff[PB-1:0]];

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      level_in    = level_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      cnt_in      = cnt_ff;
      swap_a_in   = swap_a_ff;
      swap_b_in   = swap_b_ff;
      pend_in     = 1'b0;
      slot_in     = slot_ff;
      last_in     = last_ff;
      exh_in      = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = k_ff;
      wr_en       = 1'b0;
      wr_addr     = req_data.position;
      wr_data     = req_data.symbol;

      if (csr_valid && csr_ready) begin
         len_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.opcode == hpg_pkg::OP_LOAD) begin
                  wr_en = 1'b1;
                  for (int j = 0; j < hpg_pkg::MAX_LEN; j++) begin
                     cnt_in[j] = '0;
                  end
                  level_in    = LB'(1);
                  count_in    = '0;
                  finished_in = 1'b0;
               end else if (finished_ff) begin
                  pend_in = 1'b1;
                  exh_in  = 1'b1;
                  slot_in = '0;
                  last_in = 1'b1;
               end else begin
                  count_in = count_ff + NB'(1);
                  n_in     = eff_len;
                  k_in     = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            rd_en   = 1'b1;
            rd_addr = k_ff;
            pend_in = 1'b1;
            slot_in = k_ff;
            last_in = (LB'(k_ff) + LB'(1) == n_ff);
            k_in    = k_ff + PB'(1);
            if (LB'(k_ff) + LB'(1) == n_ff) begin
               i_in     = level_ff;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (i_ff >= n_ff) begin
               level_in    = i_ff;
               finished_in = 1'b1;
               state_in    = S_IDLE;
            end else if (LB'(cur_cnt) < i_ff) begin
               swap_a_in            = i_ff[0] ? cur_cnt : '0;
               swap_b_in            = i_ff[PB-1:0];
               cnt_in[i_ff[PB-1:0]] = cur_cnt + PB'(1);
               level_in             = LB'(1);
               state_in             = S_RDA;
            end else begin
               cnt_in[i_ff[PB-1:0]] = '0;
               i_in                 = i_ff + LB'(1);
            end
         end
         S_RDA: begin
            rd_en    = 1'b1;
            rd_addr  = swap_a_ff;
            state_in = S_RDB;
         end
         S_RDB: begin
            rd_en    = 1'b1;
            rd_addr  = swap_b_ff;
            state_in = S_WRA;
         end
         S_WRA: begin
            wr_en    = 1'b1;
            wr_addr  = swap_a_ff;
            wr_data  = rd_ff;
            state_in = S_WRB;
         end
         S_WRB: begin
            wr_en    = 1'b1;
            wr_addr  = swap_b_ff;
            wr_data  = tmp_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= store_ff[rd_addr];
      end
      if (state_ff == S_RDB) begin
         tmp_ff <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      k_ff      <= k_in;
      i_ff      <= i_in;
      swap_a_ff <= swap_a_in;
      swap_b_ff <= swap_b_in;
      slot_ff   <= slot_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         len_ff      <= LB'(hpg_pkg::MAX_LEN);
         level_ff    <= LB'(1);
         count_ff    <= '0;
         finished_ff <= 1'b0;
         pend_ff     <= 1'b0;
         exh_ff      <= 1'b0;
         for (int j = 0; j < hpg_pkg::MAX_LEN; j++) begin
            cnt_ff[j] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         len_ff      <= len_in;
         level_ff    <= level_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
         pend_ff     <= pend_in;
         exh_ff      <= exh_in;
         cnt_ff      <= cnt_in;
      end
   end

   assign rsp_valid             = pend_ff;
   assign rsp_data.slot         = slot_ff;
   assign rsp_data.value        = exh_ff ? '0 : rd_ff;
   assign rsp_data.perm_number  = exh_ff ? '0 : count_ff;
   assign rsp_data.last         = last_ff;
   assign rsp_data.exhausted    = exh_ff;

endmodule

/* rtl/hpg_checker.sv */
// ----------------------------------------------------------------------------
// hpg_checker
// Port-level checks of the Heap permutation generator, bound to the top.
// ----------------------------------------------------------------------------
module hpg_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input hpg_pkg::req_type             req_data,
   input logic                         rsp_valid,
   input hpg_pkg::rsp_type             rsp_data,
   input logic                         csr_ready
);

   logic cmd_beat;
   assign cmd_beat = start && !busy;

   exhausted_beat_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exhausted |->
         rsp_data.last && rsp_data.perm_number == '0 && rsp_data.slot == '0)
      else $error("exhausted beat malformed");

   slots_run_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=>
         rsp_valid && !rsp_data.exhausted &&
         rsp_data.slot == hpg_pkg::POS_BITS'($past(rsp_data.slot) + 1) &&
         rsp_data.perm_number == $past(rsp_data.perm_number))
      else $error("permutation beats broken");

   load_is_silent: assert property (@(posedge clock) disable iff (reset)
      cmd_beat && req_data.opcode == hpg_pkg::OP_LOAD |=> !rsp_valid && !busy)
      else $error("load produced a beat");

   next_gets_answer: assert property (@(posedge clock) disable iff (reset)
      cmd_beat && req_data.opcode == hpg_pkg::OP_NEXT |=>
         busy || (rsp_valid && rsp_data.exhausted))
      else $error("next command ignored");

   csr_held_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready)
      else $error("register write open while busy");

endmodule

bind heap_permutation_generator hpg_checker u_hpg_checker (.*);
